// File: sv/drd_pkg.sv
// ----------------------------------------------------------------------------
// drd_pkg
// Shared types and codes for the duplicate row detector: channel payloads,
// the command word passed from the front end to the back end, command codes.
// ----------------------------------------------------------------------------
package drd_pkg;

   // Widest command fields; modules keep only the bits their parameters need
   localparam int POS_BITS_MAX  = 8;
   localparam int ELEM_BITS_MAX = 64;

   // Command codes carried through the queue
   localparam logic [1:0] CMD_CLEAR   = 2'd0;
   localparam logic [1:0] CMD_ELEM    = 2'd1;
   localparam logic [1:0] CMD_TOOLONG = 2'd2;

   typedef struct packed {
      logic               action;
      logic signed [31:0] element_value;
      logic               row_last;
   } req_payload_type;

   typedef struct packed {
      logic is_duplicate;
      logic table_full;
      logic row_too_long;
   } rsp_payload_type;

   typedef struct packed {
      logic [1:0]               kind;
      logic                     last;
      logic [POS_BITS_MAX-1:0]  pos;
      logic [ELEM_BITS_MAX-1:0] elem;
   } cmd_type;

endpackage

// File: sv/drd_chan_if.sv
// ----------------------------------------------------------------------------
// drd_chan_if
// Valid/ready channel; a transaction moves when valid and ready are both high.
// ----------------------------------------------------------------------------
interface drd_chan_if #(
   parameter type payload_type = logic
);
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

// File: sv/duplicate_row_detector.sv
// A row's result is registered once its last element has been scanned against
// every held row and the finish step has run. Each element is scanned against
// all held rows through the read ports of the row memories before the next
// queued command is taken; a row end adds the finish step.
// Reset: synchronous; clears the row count, queue and result valid flag. Row
// memories are not cleared and need no clearing pass.
// ----------------------------------------------------------------------------
// duplicate_row_detector
// Streaming duplicate-row detector: reports for each row whether an identical
// row was seen since the last clear, or that the row was too long or the store
// was full, keeping new rows in a row store.
module duplicate_row_detector #(
   parameter int MAX_ROWS      = 64,
   parameter int MAX_LEN       = 16,
   parameter int ELEMENT_WIDTH = 32
) (
   input  logic        clock,
   input  logic        reset,
   drd_chan_if.sink    req_chan,
   drd_chan_if.source  rsp_chan
);
   import drd_pkg::*;

   cmd_type push_data, pop_data;
   logic    push, full, pop, empty;

   // Accept and classify
   drd_front #(
      .MAX_LEN (MAX_LEN)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_chan.valid),
      .req_ready   (req_chan.ready),
      .req_payload (req_chan.payload),
      .cmd_push    (push),
      .cmd_data    (push_data),
      .cmd_full    (full)
   );

   // Decouple front and back
   drd_fifo #(
      .DEPTH (4)
   ) u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .full      (full),
      .pop       (pop),
      .pop_data  (pop_data),
      .empty     (empty)
   );

   // Match, stage and commit
   drd_back #(
      .MAX_ROWS      (MAX_ROWS),
      .MAX_LEN       (MAX_LEN),
      .ELEMENT_WIDTH (ELEMENT_WIDTH)
   ) u_back (
      .clock       (clock),
      .reset       (reset),
      .q_empty     (empty),
      .q_data      (pop_data),
      .q_pop       (pop),
      .rsp_valid   (rsp_chan.valid),
      .rsp_ready   (rsp_chan.ready),
      .rsp_payload (rsp_chan.payload)
   );
endmodule

// File: sv/drd_ram.sv
// ----------------------------------------------------------------------------
// drd_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module drd_ram #(
   parameter int WIDTH      = 32,
   parameter int DEPTH      = 64,
   parameter int ADDR_WIDTH = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic                  clock,
   input  logic                  wr_en,
   input  logic [ADDR_WIDTH-1:0] wr_addr,
   input  logic [WIDTH-1:0]      wr_data,
   input  logic [ADDR_WIDTH-1:0] rd_addr,
   output logic [WIDTH-1:0]      rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write and registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule

// File: sv/drd_fifo.sv
// ----------------------------------------------------------------------------
// drd_fifo
// Short command queue between the front end and the back end.
// ----------------------------------------------------------------------------
module drd_fifo #(
   parameter int DEPTH = 4
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  drd_pkg::cmd_type  push_data,
   output logic              full,
   input  logic              pop,
   output drd_pkg::cmd_type  pop_data,
   output logic              empty
);
   import drd_pkg::*;

   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);
   localparam logic [PW-1:0] LAST_SLOT = PW'(DEPTH - 1);

   cmd_type        slot_ff [DEPTH];
   logic [PW-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]  count_ff, count_in;
   logic           do_push, do_pop;

   assign full     = (count_ff == CW'(DEPTH));
   assign empty    = (count_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_data = slot_ff[rd_ptr_ff];

   // Advance pointers and occupancy
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_SLOT) ? '0 : PW'(wr_ptr_ff + 1'b1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_SLOT) ? '0 : PW'(rd_ptr_ff + 1'b1);
      end
      if (do_push && !do_pop) begin
         count_in = CW'(count_ff + 1'b1);
      end else if (do_pop && !do_push) begin
         count_in = CW'(count_ff - 1'b1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Store pushed commands
   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end
endmodule

// File: sv/drd_front.sv
// ----------------------------------------------------------------------------
// drd_front
// Accepts input transactions, tracks the position within the current row and
// classifies each one into a clear, a row element or an overlong row end.
// ----------------------------------------------------------------------------
module drd_front #(
   parameter int MAX_LEN = 16
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  drd_pkg::req_payload_type req_payload,
   output logic                     cmd_push,
   output drd_pkg::cmd_type         cmd_data,
   input  logic                     cmd_full
);
   import drd_pkg::*;

   localparam int LW = $clog2(MAX_LEN + 1);
   localparam logic [LW-1:0] LEN_MAX = LW'(MAX_LEN);

   logic [LW-1:0] pos_ff, pos_in;
   logic          accept;

   assign req_ready = !cmd_full;
   assign accept    = req_valid && req_ready;

   // Classify the accepted transaction
   always_comb begin
      pos_in        = pos_ff;
      cmd_push      = 1'b0;
      cmd_data.kind = CMD_ELEM;
      cmd_data.last = req_payload.row_last;
      cmd_data.pos  = POS_BITS_MAX'(pos_ff);
      cmd_data.elem = {{(ELEM_BITS_MAX - 32){req_payload.element_value[31]}},
                       req_payload.element_value};
      if (accept) begin
         if (req_payload.action) begin
            cmd_data.kind = CMD_CLEAR;
            cmd_push      = 1'b1;
            pos_in        = '0;
         end else if (pos_ff == LEN_MAX) begin
            // Past the maximum length: drop the element, report at row end
            if (req_payload.row_last) begin
               cmd_data.kind = CMD_TOOLONG;
               cmd_push      = 1'b1;
               pos_in        = '0;
            end
         end else begin
            cmd_push = 1'b1;
            pos_in   = req_payload.row_last ? '0 : LW'(pos_ff + 1'b1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff <= '0;
      end else begin
         pos_ff <= pos_in;
      end
   end
endmodule

// File: sv/drd_back.sv
// ----------------------------------------------------------------------------
// drd_back
// Executes queued commands: stages row elements into the free slot, scans the
// held rows one per cycle to update their match bits, and commits new rows.
// ----------------------------------------------------------------------------
module drd_back #(
   parameter int MAX_ROWS      = 64,
   parameter int MAX_LEN       = 16,
   parameter int ELEMENT_WIDTH = 32
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     q_empty,
   input  drd_pkg::cmd_type         q_data,
   output logic                     q_pop,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output drd_pkg::rsp_payload_type rsp_payload
);
   import drd_pkg::*;

   localparam int RW = $clog2(MAX_ROWS);
   localparam int HW = $clog2(MAX_ROWS + 1);
   localparam int PW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
   localparam int LW = $clog2(MAX_LEN + 1);
   localparam int EW = ELEMENT_WIDTH;
   localparam int STORE_DEPTH = MAX_ROWS << PW;
   localparam logic [HW-1:0] ROWS_MAX = HW'(MAX_ROWS);

   localparam logic [1:0] ST_IDLE   = 2'd0;
   localparam logic [1:0] ST_SCAN   = 2'd1;
   localparam logic [1:0] ST_FINISH = 2'd2;

   logic [1:0]      state_ff, state_in;
   logic [HW-1:0]   held_ff, held_in;
   logic [HW-1:0]   idx_ff, idx_in;
   logic            rd_valid_ff, rd_valid_in;
   logic [RW-1:0]   rd_row_ff, rd_row_in;
   logic [PW-1:0]   pos_ff, pos_in;
   logic [EW-1:0]   elem_ff, elem_in;
   logic            last_ff, last_in;
   logic            dup_ff, dup_in;
   logic            rsp_valid_ff, rsp_valid_in;
   rsp_payload_type rsp_ff, rsp_in;

   logic            rsp_free, issue, has_room, new_match;
   logic [LW-1:0]   pos_ext, len_next;
   logic            store_we, len_we;
   logic [RW+PW-1:0] store_waddr;
   logic [EW-1:0]   store_rd;
   logic [LW-1:0]   len_rd;
   logic [0:0]      match_rd;

   assign rsp_free = !rsp_valid_ff || rsp_ready;
   assign has_room = (held_ff < ROWS_MAX);
   assign issue    = (idx_ff < held_ff);
   assign pos_ext  = LW'(pos_ff);
   assign len_next = LW'(pos_ext + 1'b1);

   // Match bit of the row whose data just came back
   assign new_match = ((pos_ff == '0) || match_rd[0]) && (pos_ext < len_rd) &&
                      (store_rd == elem_ff);

   // Control: pop, scan, finish
   always_comb begin
      state_in     = state_ff;
      held_in      = held_ff;
      idx_in       = idx_ff;
      rd_valid_in  = 1'b0;
      rd_row_in    = idx_ff[RW-1:0];
      pos_in       = pos_ff;
      elem_in      = elem_ff;
      last_in      = last_ff;
      dup_in       = dup_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_in       = rsp_ff;
      q_pop        = 1'b0;
      store_we     = 1'b0;
      store_waddr  = {held_ff[RW-1:0], q_data.pos[PW-1:0]};
      len_we       = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (!q_empty) begin
               unique case (q_data.kind)
                  CMD_CLEAR: begin
                     q_pop   = 1'b1;
                     held_in = '0;
                  end
                  CMD_ELEM: begin
                     q_pop    = 1'b1;
                     store_we = has_room;
                     pos_in   = q_data.pos[PW-1:0];
                     elem_in  = q_data.elem[EW-1:0];
                     last_in  = q_data.last;
                     idx_in   = '0;
                     dup_in   = 1'b0;
                     state_in = ST_SCAN;
                  end
                  CMD_TOOLONG: begin
                     if (rsp_free) begin
                        q_pop               = 1'b1;
                        rsp_valid_in        = 1'b1;
                        rsp_in              = '0;
                        rsp_in.row_too_long = 1'b1;
                     end
                  end
                  default: begin
                     q_pop = 1'b1;
                  end
               endcase
            end
         end
         ST_SCAN: begin
            // Issue one held row per cycle, retire it in the following cycle
            if (issue) begin
               idx_in      = HW'(idx_ff + 1'b1);
               rd_valid_in = 1'b1;
            end
            if (rd_valid_ff && last_ff && new_match && (len_rd == len_next)) begin
               dup_in = 1'b1;
            end
            if (!issue && !rd_valid_ff) begin
               state_in = last_ff ? ST_FINISH : ST_IDLE;
            end
         end
         ST_FINISH: begin
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               rsp_in       = '0;
               if (dup_ff) begin
                  rsp_in.is_duplicate = 1'b1;
               end else if (has_room) begin
                  len_we  = 1'b1;
                  held_in = HW'(held_ff + 1'b1);
               end else begin
                  rsp_in.table_full = 1'b1;
               end
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         held_ff      <= '0;
         idx_ff       <= '0;
         rd_valid_ff  <= 1'b0;
         dup_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         held_ff      <= held_in;
         idx_ff       <= idx_in;
         rd_valid_ff  <= rd_valid_in;
         dup_ff       <= dup_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      rd_row_ff <= rd_row_in;
      pos_ff    <= pos_in;
      elem_ff   <= elem_in;
      last_ff   <= last_in;
      rsp_ff    <= rsp_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   // Row elements, one row per slot
   drd_ram #(
      .WIDTH      (EW),
      .DEPTH      (STORE_DEPTH),
      .ADDR_WIDTH (RW + PW)
   ) u_store (
      .clock   (clock),
      .wr_en   (store_we),
      .wr_addr (store_waddr),
      .wr_data (q_data.elem[EW-1:0]),
      .rd_addr ({idx_ff[RW-1:0], pos_ff}),
      .rd_data (store_rd)
   );

   // Committed row lengths
   drd_ram #(
      .WIDTH      (LW),
      .DEPTH      (MAX_ROWS),
      .ADDR_WIDTH (RW)
   ) u_lengths (
      .clock   (clock),
      .wr_en   (len_we),
      .wr_addr (held_ff[RW-1:0]),
      .wr_data (len_next),
      .rd_addr (idx_ff[RW-1:0]),
      .rd_data (len_rd)
   );

   // Per-row match bits of the current row
   drd_ram #(
      .WIDTH      (1),
      .DEPTH      (MAX_ROWS),
      .ADDR_WIDTH (RW)
   ) u_match (
      .clock   (clock),
      .wr_en   (rd_valid_ff),
      .wr_addr (rd_row_ff),
      .wr_data (new_match),
      .rd_addr (idx_ff[RW-1:0]),
      .rd_data (match_rd)
   );

`ifndef SYNTH
   a_held_bound: assert property (@(posedge clock) disable iff (reset)
      held_ff <= ROWS_MAX)
      else $error("row count above table size");

   a_one_flag: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> ($countones(rsp_ff) <= 1))
      else $error("more than one result flag set");

   a_scan_index: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN) |-> (idx_ff <= held_ff))
      else $error("scan index past held rows");

   a_clear_empties: assert property (@(posedge clock) disable iff (reset)
      (q_pop && (state_ff == ST_IDLE) && (q_data.kind == CMD_CLEAR)) |=> (held_ff == '0))
      else $error("clear did not empty the table");
`endif
endmodule

// File: tb/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the duplicate row detector. Streams matrix rows
// (directed corner rows, then random rows that repeat, vary and overflow the
// row store) through the request channel. A cycle-free copy of the detector
// state predicts the flags of every row, and each response is compared
// against the oldest prediction.
// ----------------------------------------------------------------------------
module tb_top;
   import drd_pkg::*;

   localparam int ROW_SLOTS   = 64;
   localparam int ROW_CAP     = 16;
   localparam int ELEM_W      = 32;
   localparam int ROW_VALS    = 20;
   localparam int CLK_HALF    = 10;
   localparam int RESET_TICKS = 12;
   localparam int ITEM_GOAL   = 2000;
   localparam int HOLD_TICKS  = 500;
   localparam int IDLE_LIMIT  = 4000;
   localparam int DRAIN_TICKS = 300;

   // Request action codes
   localparam logic ACT_PUSH  = 1'b0;
   localparam logic ACT_CLEAR = 1'b1;

   typedef struct {
      logic [ELEM_W-1:0] vals [ROW_VALS];
      int                len;
   } row_type;

   // Tracks the row store contents and predicts the flags of each row
   class dup_row_predictor;
      logic [ELEM_W-1:0] held_vals [ROW_SLOTS][ROW_CAP];
      int unsigned       held_len [ROW_SLOTS];
      int unsigned       rows_held;
      bit [ROW_SLOTS-1:0] still_equal;
      int unsigned       position;
      bit                overlong;
      rsp_payload_type   expected_flags [$];
      int unsigned       mismatches;
      int unsigned       rows_done;
      int unsigned       dup_rows;
      int unsigned       full_rows;
      int unsigned       long_rows;
      int unsigned       clears;

      function new();
         rows_held  = 0;
         mismatches = 0;
         rows_done  = 0;
         dup_rows   = 0;
         full_rows  = 0;
         long_rows  = 0;
         clears     = 0;
         restart_row();
      endfunction

      function void restart_row();
         still_equal = '1;
         position    = 0;
         overlong    = 1'b0;
      endfunction

      // Advance the state by one accepted transaction
      function void take_request(req_payload_type t);
         logic [ELEM_W-1:0] v;
         rsp_payload_type   r;
         bit                dup;
         if (t.action == ACT_CLEAR) begin
            rows_held = 0;
            clears++;
            restart_row();
            return;
         end
         v = t.element_value;
         if (position >= ROW_CAP) begin
            overlong = 1'b1;
         end else begin
            for (int i = 0; i < ROW_SLOTS; i++) begin
               if (i < rows_held) begin
                  if (position >= held_len[i] || held_vals[i][position] != v)
                     still_equal[i] = 1'b0;
               end
            end
            // stage the element in the first free slot
            if (rows_held < ROW_SLOTS)
               held_vals[rows_held][position] = v;
            position++;
         end
         if (!t.row_last)
            return;
         r = '0;
         if (overlong) begin
            r.row_too_long = 1'b1;
            long_rows++;
         end else begin
            dup = 1'b0;
            for (int i = 0; i < ROW_SLOTS; i++) begin
               if (i < rows_held && still_equal[i] && held_len[i] == position)
                  dup = 1'b1;
            end
            if (dup) begin
               r.is_duplicate = 1'b1;
               dup_rows++;
            end else if (rows_held < ROW_SLOTS) begin
               held_len[rows_held] = position;
               rows_held++;
            end else begin
               r.table_full = 1'b1;
               full_rows++;
            end
         end
         rows_done++;
         expected_flags.push_back(r);
         restart_row();
      endfunction

      // Compare one response with the oldest prediction
      function void check_flags(rsp_payload_type got);
         rsp_payload_type want;
         if (expected_flags.size() == 0) begin
            $error("unexpected response %b with no row pending", got);
            mismatches++;
            return;
         end
         want = expected_flags.pop_front();
         if (got.is_duplicate !== want.is_duplicate) begin
            $error("is_duplicate: expected %0b, actual %0b",
                   want.is_duplicate, got.is_duplicate);
            mismatches++;
         end
         if (got.table_full !== want.table_full) begin
            $error("table_full: expected %0b, actual %0b",
                   want.table_full, got.table_full);
            mismatches++;
         end
         if (got.row_too_long !== want.row_too_long) begin
            $error("row_too_long: expected %0b, actual %0b",
                   want.row_too_long, got.row_too_long);
            mismatches++;
         end
      endfunction

      function int pending();
         return expected_flags.size();
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset;

   drd_chan_if #(.payload_type(req_payload_type)) req_if ();
   drd_chan_if #(.payload_type(rsp_payload_type)) rsp_if ();

   duplicate_row_detector #(
      .MAX_ROWS      (ROW_SLOTS),
      .MAX_LEN       (ROW_CAP),
      .ELEMENT_WIDTH (ELEM_W)
   ) uut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_if),
      .rsp_chan (rsp_if)
   );

   dup_row_predictor board;

   int unsigned items_sent   = 0;
   int unsigned burst_left   = 0;
   int unsigned results_seen = 0;
   int unsigned hold_left    = 0;
   int unsigned pat_age      = 0;
   int unsigned pat_idx      = 0;
   logic [7:0]  stall_pat    = 8'hFF;
   int unsigned idle_ticks   = 0;

   always #(CLK_HALF) clock = ~clock;

   // Offer one transaction, inserting a random gap when the burst runs out
   task automatic push_item(req_payload_type p);
      int unsigned gap;
      if (burst_left == 0) begin
         gap = $urandom_range(1, 8);
         req_if.valid <= 1'b0;
         repeat (gap) @(posedge clock);
         case ($urandom_range(0, 9)) inside
            [0:4]:   burst_left = $urandom_range(1, 4);
            [5:7]:   burst_left = $urandom_range(5, 20);
            default: burst_left = $urandom_range(30, 80);
         endcase
      end
      req_if.valid   <= 1'b1;
      req_if.payload <= p;
      do @(posedge clock); while (!req_if.ready);
      board.take_request(p);
      burst_left--;
      items_sent++;
   endtask

   task automatic send_element(logic [ELEM_W-1:0] v, logic last);
      req_payload_type p;
      p.action        = ACT_PUSH;
      p.element_value = v;
      p.row_last      = last;
      push_item(p);
   endtask

   // Clear carries random filler in the ignored fields
   task automatic send_clear();
      req_payload_type p;
      p.action        = ACT_CLEAR;
      p.element_value = $urandom;
      p.row_last      = 1'($urandom_range(0, 1));
      push_item(p);
   endtask

   task automatic send_row(row_type r);
      for (int i = 0; i < r.len; i++)
         send_element(r.vals[i], i == r.len - 1);
   endtask

   // Hold the request side low until every predicted response has arrived
   task automatic hold_until_drained();
      req_if.valid <= 1'b0;
      @(posedge clock);
      while (board.pending() > 0) @(posedge clock);
      burst_left = 0;
   endtask

   function automatic logic [ELEM_W-1:0] pick_value();
      case ($urandom_range(0, 9)) inside
         0:       return 32'h0000_0000;
         1:       return 32'hFFFF_FFFF;
         2:       return 32'h7FFF_FFFF;
         3:       return 32'h8000_0000;
         [4:5]:   return $urandom_range(0, 3);
         default: return $urandom;
      endcase
   endfunction

   function automatic row_type fresh_row(int len);
      row_type r;
      r.len = len;
      for (int i = 0; i < ROW_VALS; i++)
         r.vals[i] = pick_value();
      return r;
   endfunction

   // Copy a held row and nudge it: flip one bit, or shorten/lengthen by one
   function automatic row_type vary_row(row_type src);
      row_type r;
      int j;
      r = src;
      case ($urandom_range(0, 2))
         0: begin
            j = $urandom_range(0, r.len - 1);
            r.vals[j] ^= 32'd1 << $urandom_range(0, ELEM_W - 1);
         end
         1: begin
            if (r.len > 1) r.len--;
            else begin
               r.vals[r.len] = pick_value();
               r.len++;
            end
         end
         default: begin
            if (r.len < ROW_CAP) begin
               r.vals[r.len] = pick_value();
               r.len++;
            end else begin
               r.len--;
            end
         end
      endcase
      return r;
   endfunction

   // Stimulus: reset, directed rows, random phases between clears
   initial begin
      row_type     cur;
      row_type     history [$];
      int unsigned rows_left;
      int unsigned cut;
      bit          paused;
      bit          is_repeat;

      board          = new();
      reset          = 1'b1;
      req_if.valid   = 1'b0;
      req_if.payload = '0;
      paused         = 1'b0;
      repeat (RESET_TICKS) @(posedge clock);
      reset <= 1'b0;

      // extremes, repeat, reversed order, prefix of a held row
      cur.len = 2;
      cur.vals[0] = 32'h7FFF_FFFF;
      cur.vals[1] = 32'h8000_0000;
      send_row(cur);
      send_row(cur);
      cur.vals[0] = 32'h8000_0000;
      cur.vals[1] = 32'h7FFF_FFFF;
      send_row(cur);
      cur.len = 1;
      send_row(cur);
      cur.vals[0] = 32'h0000_0000;
      send_row(cur);
      send_row(cur);
      cur.vals[0] = 32'hFFFF_FFFF;
      send_row(cur);
      // clear drops a partial row; the same value is then new again
      send_element(32'd5, 1'b0);
      send_clear();
      cur.vals[0] = 32'd5;
      send_row(cur);
      send_row(cur);
      // rows held before the clear are gone
      cur.vals[0] = 32'h0000_0000;
      send_row(cur);

      rows_left = 0;
      while (items_sent < ITEM_GOAL) begin
         if (rows_left == 0) begin
            send_clear();
            history.delete();
            if ($urandom_range(0, 9) < 6) rows_left = $urandom_range(5, 40);
            else                          rows_left = $urandom_range(70, 120);
         end

         // pause once until the detector has drained
         if (!paused && items_sent >= ITEM_GOAL / 2) begin
            hold_until_drained();
            paused = 1'b1;
         end

         is_repeat = 1'b0;
         case ($urandom_range(0, 99)) inside
            [0:34]: begin
               if (history.size() > 0) begin
                  cur = history[$urandom_range(0, history.size() - 1)];
                  is_repeat = 1'b1;
               end else begin
                  cur = fresh_row($urandom_range(1, 3));
               end
            end
            [35:49]: begin
               if (history.size() > 0)
                  cur = vary_row(history[$urandom_range(0, history.size() - 1)]);
               else
                  cur = fresh_row($urandom_range(1, 3));
            end
            [50:89]: begin
               if ($urandom_range(0, 9) < 7) cur = fresh_row($urandom_range(1, 3));
               else                          cur = fresh_row($urandom_range(4, ROW_CAP));
            end
            [90:96]: cur = fresh_row($urandom_range(ROW_CAP + 1, ROW_VALS));
            default: begin
               // broken row: a few elements, then a clear
               cur = fresh_row($urandom_range(2, ROW_CAP));
               cut = $urandom_range(1, cur.len - 1);
               for (int i = 0; i < cut; i++)
                  send_element(cur.vals[i], 1'b0);
               send_clear();
               history.delete();
               rows_left = $urandom_range(5, 40);
               continue;
            end
         endcase

         send_row(cur);
         if (!is_repeat && cur.len <= ROW_CAP)
            history.push_back(cur);
         rows_left--;
      end

      // close out: drain, then watch for stray responses
      req_if.valid <= 1'b0;
      while (board.pending() > 0) @(posedge clock);
      repeat (DRAIN_TICKS) @(posedge clock);

      $display("Covered %0d rows in %0d transactions: %0d repeats, %0d refused on full store,",
               board.rows_done, items_sent, board.dup_rows, board.full_rows);
      $display("%0d over length, %0d store clears.", board.long_rows, board.clears);
      if (board.mismatches == 0) begin
         $display("PASS duplicate_row_detector");
      end else begin
         $display("FAIL duplicate_row_detector");
      end
      $finish;
   end

   // Response side: check each transaction, stall on a shifting pattern,
   // hold off for a long stretch twice so the input backs up
   always @(posedge clock) begin
      if (reset) begin
         rsp_if.ready <= 1'b0;
      end else begin
         if (rsp_if.valid && rsp_if.ready) begin
            board.check_flags(rsp_if.payload);
            results_seen++;
            if (results_seen == 100 || results_seen == 400)
               hold_left = HOLD_TICKS;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_if.ready <= 1'b0;
         end else begin
            if (pat_age == 0) begin
               pat_age = $urandom_range(20, 80);
               if ($urandom_range(0, 9) < 3) stall_pat = 8'hFF;
               else                          stall_pat = 8'($urandom);
               if (stall_pat == 8'h00) stall_pat = 8'h01;
            end
            pat_age--;
            pat_idx = (pat_idx + 1) % 8;
            rsp_if.ready <= stall_pat[pat_idx];
         end
      end
   end

   // Watchdog: end the run when neither channel moves for too long
   always @(posedge clock) begin
      if (reset || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
         idle_ticks = 0;
      end else begin
         idle_ticks++;
         if (idle_ticks >= IDLE_LIMIT) begin
            $display("Timeout: no transaction for %0d cycles", IDLE_LIMIT);
            $display("FAIL duplicate_row_detector");
            $finish;
         end
      end
   end

endmodule
